/* rtl/core/b64d_pkg.sv */
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3d;
    localparam logic [5:0] SEXTET_MASK = 6'h3f;

    // Result queue depth. Four entries cover one full group plus one word in flight.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_BAD_CHAR   = 2'd1,
        ERR_LENGTH     = 2'd2,
        ERR_PAD_SECOND = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_byte;
        t_err       error_kind;
        logic       string_end;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } t_sextet;

    // Maps one character to its 6-bit value; characters outside the alphabet map to zero.
    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet    s;
        logic [7:0] d;
        s = '0;
        d = 8'h00;
        if (c >= 8'h41 && c <= 8'h5a) begin
            d = c - 8'h41;
            s.ok = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            d = c - 8'h61 + 8'd26;
            s.ok = 1'b1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
            s.ok = 1'b1;
        end else if (c == 8'h2b) begin
            d = 8'd62;
            s.ok = 1'b1;
        end else if (c == 8'h2f) begin
            d = 8'd63;
            s.ok = 1'b1;
        end
        s.value = d[5:0] & SEXTET_MASK;
        return s;
    endfunction

endpackage

/* rtl/core/base64_stream_decoder.sv */
// Streaming base64 decoder for the standard alphabet with '=' padding.
// Input channel: one character word per handshake (i_valid / o_ready), with
// i_last_char set on the final character of a string. Output channel: one
// result word per handshake (o_valid / i_ready) carrying a decoded byte, an
// error code and a flag on the final result of the string.
// Each accepted character lands in an input register. From there it is
// decoded against the group state and its results, zero to three words, are
// written into a four-entry result queue in one go. A result word is thus
// registered in the input register and then in the queue on its way to the
// output. One character is taken per cycle while the queue has room for the
// results of the held one. A character waits in the input register while
// the queue lacks room for all of its results, so a group's fourth character
// needs the queue at most one entry full.
// A stalled receiver fills the queue and then holds the input register, at
// which point o_ready drops; nothing is lost or repeated.
// Reset clears the group position, the discard flag, the input register and
// the queue; held characters need no reset as each is written before use.
module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_error_kind,
    output logic       o_string_end
);
    import b64d_pkg::*;

    logic                 r_in_valid;
    t_in_word             r_in_word;
    logic [1:0]           dec_num;
    t_result [2:0]        dec_lanes;
    logic [FIFO_CW-1:0]   fifo_free;
    logic                 advance;
    t_result              head;

    // The held character moves on when every one of its results fits the queue.
    assign advance = r_in_valid && (fifo_free >= FIFO_CW'(dec_num));
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_word.char_code <= i_char_code;
            r_in_word.last_char <= i_last_char;
        end
    end

    b64d_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (r_in_word),
        .o_num     (dec_num),
        .o_lanes   (dec_lanes)
    );

    b64d_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_num   (dec_num),
        .i_lanes (dec_lanes),
        .o_free  (fifo_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (head)
    );

    assign o_data_byte  = head.data_byte;
    assign o_error_kind = head.error_kind;
    assign o_string_end = head.string_end;

endmodule

/* rtl/core/b64d_decode.sv */
module b64d_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  b64d_pkg::t_in_word         i_word,
    output logic [1:0]                 o_num,
    output b64d_pkg::t_result [2:0]    o_lanes
);
    import b64d_pkg::*;

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic       r_disc;
    logic       n_disc;
    logic [7:0] r_held [3];
    logic       held_we;

    t_sextet    s0, s1, s2, s3;
    logic       pad_held;
    logic       is_pad;
    logic       err_en;
    t_err       err_code;
    logic       err_last;

    always_comb begin
        s0     = sextet_of(r_held[0]);
        s1     = sextet_of(r_held[1]);
        s2     = sextet_of(r_held[2]);
        s3     = sextet_of(i_word.char_code);
        is_pad = (i_word.char_code == PAD_CHAR);

        pad_held = 1'b0;
        if (r_pos == 2'd2) begin
            pad_held = (r_held[1] == PAD_CHAR);
        end else if (r_pos == 2'd3) begin
            pad_held = (r_held[1] == PAD_CHAR) || (r_held[2] == PAD_CHAR);
        end

        n_pos    = r_pos;
        n_disc   = r_disc;
        held_we  = 1'b0;
        err_en   = 1'b0;
        err_code = ERR_NONE;
        err_last = 1'b0;
        o_num    = 2'd0;
        o_lanes  = '0;

        if (r_disc) begin
            if (i_word.last_char) begin
                n_disc = 1'b0;
                n_pos  = 2'd0;
            end
        end else if (i_word.last_char && r_pos != 2'd3) begin
            err_en   = 1'b1;
            err_code = ERR_LENGTH;
            err_last = 1'b1;
        end else if (r_pos != 2'd3) begin
            if ((is_pad && r_pos == 2'd0) || (!is_pad && !s3.ok && !pad_held)) begin
                err_en   = 1'b1;
                err_code = ERR_BAD_CHAR;
            end else begin
                held_we = 1'b1;
                n_pos   = r_pos + 2'd1;
            end
        end else if (!i_word.last_char) begin
            if (pad_held || is_pad || !s3.ok) begin
                err_en   = 1'b1;
                err_code = ERR_BAD_CHAR;
            end
        end else if (r_held[1] == PAD_CHAR) begin
            err_en   = 1'b1;
            err_code = ERR_PAD_SECOND;
            err_last = 1'b1;
        end else if (r_held[2] != PAD_CHAR && !is_pad && !s3.ok) begin
            err_en   = 1'b1;
            err_code = ERR_BAD_CHAR;
            err_last = 1'b1;
        end

        if (err_en) begin
            o_num                 = 2'd1;
            o_lanes[0].error_kind = err_code;
            o_lanes[0].string_end = 1'b1;
            n_disc                = !err_last;
            n_pos                 = 2'd0;
        end else if (!r_disc && r_pos == 2'd3) begin
            // A complete group: three bytes, fewer when the last group is padded.
            n_pos                = 2'd0;
            o_lanes[0].data_byte = {s0.value, s1.value[5:4]};
            o_lanes[1].data_byte = {s1.value[3:0], s2.value[5:2]};
            o_lanes[2].data_byte = {s2.value[1:0], s3.value};
            if (i_word.last_char && r_held[2] == PAD_CHAR) begin
                o_num                 = 2'd1;
                o_lanes[0].string_end = 1'b1;
            end else if (i_word.last_char && is_pad) begin
                o_num                 = 2'd2;
                o_lanes[1].string_end = 1'b1;
            end else begin
                o_num                 = 2'd3;
                o_lanes[2].string_end = i_word.last_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_disc <= 1'b0;
        end else if (i_advance) begin
            r_pos  <= n_pos;
            r_disc <= n_disc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && held_we) begin
            r_held[r_pos] <= i_word.char_code;
        end
    end

endmodule

/* rtl/core/b64d_out_fifo.sv */
module b64d_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic [1:0]                          i_num,
    input  b64d_pkg::t_result [2:0]             i_lanes,
    output logic [b64d_pkg::FIFO_CW-1:0]        o_free,
    output logic                                o_valid,
    input  logic                                i_ready,
    output b64d_pkg::t_result                   o_head
);
    import b64d_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;
    logic [FIFO_CW-1:0]   n_count;
    logic [FIFO_CW-1:0]   push_num;
    logic                 pop;

    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign o_free   = FIFO_CW'(FIFO_DEPTH) - r_count;
    assign pop      = o_valid && i_ready;
    assign push_num = i_push ? FIFO_CW'(i_num) : '0;
    assign n_count  = r_count + push_num - FIFO_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_num[FIFO_AW-1:0];
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_push && k < int'(i_num)) begin
                r_mem[r_wr_ptr + FIFO_AW'(k)] <= i_lanes[k];
            end
        end
    end

endmodule

/* tb/b64_decode_checker.sv */
module b64_decode_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_data_byte,
    input  logic [1:0] i_error_kind,
    input  logic       i_string_end,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    import b64d_pkg::*;

    logic [1:0] group_pos;
    logic [7:0] held_chars [3];
    logic       discarding;
    t_result    decoded_queue [$];
    t_result    oldest;
    int         fail_count = 0;
    int         checked    = 0;

    // Returns 1 when the character belongs to the alphabet; v is zero otherwise.
    function automatic logic alphabet_index(input logic [7:0] c, output logic [5:0] v);
        v = 6'd0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            v = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            v = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2b) begin
            v = 6'd62;
        end else if (c == 8'h2f) begin
            v = 6'd63;
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic push_word(input logic [7:0] b, input t_err k, input logic e);
        t_result r;
        r.data_byte  = b;
        r.error_kind = k;
        r.string_end = e;
        decoded_queue = {decoded_queue, r};
    endtask

    task automatic push_error(input t_err k, input logic l);
        push_word(8'h00, k, 1'b1);
        discarding = !l;
        group_pos  = 2'd0;
    endtask

    // Advances the group state by one character and queues the words it yields.
    task automatic decode_character(input logic [7:0] c, input logic l);
        logic       pad_held;
        logic       ok;
        logic [5:0] v0, v1, v2, v3;
        if (discarding) begin
            if (l) begin
                discarding = 1'b0;
                group_pos  = 2'd0;
            end
            return;
        end
        if (l && group_pos != 2'd3) begin
            push_error(ERR_LENGTH, 1'b1);
            return;
        end
        pad_held = (group_pos >= 2'd2 && held_chars[1] == PAD_CHAR) ||
                   (group_pos == 2'd3 && held_chars[2] == PAD_CHAR);
        ok = alphabet_index(c, v3);
        if (group_pos != 2'd3) begin
            if (c == PAD_CHAR) begin
                if (group_pos == 2'd0) begin
                    push_error(ERR_BAD_CHAR, 1'b0);
                    return;
                end
            end else if (!ok && !pad_held) begin
                push_error(ERR_BAD_CHAR, 1'b0);
                return;
            end
            held_chars[group_pos] = c;
            group_pos++;
            return;
        end
        if (!l) begin
            if (pad_held || c == PAD_CHAR || !ok) begin
                push_error(ERR_BAD_CHAR, 1'b0);
                return;
            end
        end else begin
            if (held_chars[1] == PAD_CHAR) begin
                push_error(ERR_PAD_SECOND, 1'b1);
                return;
            end
            if (held_chars[2] != PAD_CHAR && c != PAD_CHAR && !ok) begin
                push_error(ERR_BAD_CHAR, 1'b1);
                return;
            end
        end
        void'(alphabet_index(held_chars[0], v0));
        void'(alphabet_index(held_chars[1], v1));
        void'(alphabet_index(held_chars[2], v2));
        group_pos = 2'd0;
        push_word({v0, v1[5:4]}, ERR_NONE, l && held_chars[2] == PAD_CHAR);
        if (l && held_chars[2] == PAD_CHAR)
            return;
        push_word({v1[3:0], v2[5:2]}, ERR_NONE, l && c == PAD_CHAR);
        if (l && c == PAD_CHAR)
            return;
        push_word({v2[1:0], v3}, ERR_NONE, l);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result word %0d: %s is 0x%0h, expected 0x%0h",
                 checked, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            group_pos  = 2'd0;
            discarding = 1'b0;
            decoded_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                decode_character(i_char_code, i_last_char);
            if (i_out_valid && i_out_ready) begin
                if (decoded_queue.size() == 0) begin
                    report_mismatch("unexpected word, data byte", i_data_byte, 0);
                end else begin
                    oldest = decoded_queue.pop_front();
                    if (i_data_byte !== oldest.data_byte)
                        report_mismatch("data byte", i_data_byte, oldest.data_byte);
                    if (i_error_kind !== oldest.error_kind)
                        report_mismatch("error kind", i_error_kind, oldest.error_kind);
                    if (i_string_end !== oldest.string_end)
                        report_mismatch("string end", i_string_end, oldest.string_end);
                    checked++;
                end
            end
        end
        o_pending    = decoded_queue.size();
        o_fail_count = fail_count;
        o_checked    = checked;
    end

endmodule

/* tb/tb_base64_stream_decoder.sv */
module tb_base64_stream_decoder;
    import b64d_pkg::*;

    typedef logic [7:0] t_chars [$];

    // Longest stretch without any word moving on either channel before the run
    // is declared hung.
    localparam int QUIET_LIMIT = 1000;
    // Settling time after the last expected word, so that stray extra words get
    // caught.
    localparam int TAIL_CYCLES = 20;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_char_code = 8'h00;
    logic       i_last_char = 1'b0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_data_byte;
    logic [1:0] o_error_kind;
    logic       o_string_end;

    int fail_count;
    int pending;
    int checked;

    // Idle control: the sender and receiver each take random bursts while
    // their flag is set. Both flags are cleared for the last part of the run.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int strings_sent = 0;
    int chars_sent = 0;
    int clean_chars = 0;

    always #2 i_clk = ~i_clk;

    base64_stream_decoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data_byte  (o_data_byte),
        .o_error_kind (o_error_kind),
        .o_string_end (o_string_end)
    );

    // The checker watches both channels, keeps its own decoder state and
    // compares every result word against the oldest predicted one.
    b64_decode_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_data_byte  (o_data_byte),
        .i_error_kind (o_error_kind),
        .i_string_end (o_string_end),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Receiver side. A stall burst starts at random and holds ready low; a burst
    // already running finishes even after idling has been switched off. Exactly
    // one assignment to i_ready happens per edge.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: any word moving on either channel restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'h41 + v;
        if (v < 6'd52)
            return 8'h61 + v - 8'd26;
        if (v < 6'd62)
            return 8'h30 + v - 8'd52;
        return (v == 6'd62) ? 8'h2b : 8'h2f;
    endfunction

    function automatic t_chars chars_of(input string txt);
        t_chars q;
        for (int i = 0; i < txt.len(); i++)
            q = {q, txt[i]};
        return q;
    endfunction

    // Presents one character word and holds it until the decoder takes it.
    // The task is always entered in the time step of a rising edge, so the
    // nonblocking drive shows up for the next edge. Valid is lowered only
    // when an idle burst follows; otherwise the next word replaces the
    // payload in the same time step and valid simply stays high.
    task automatic send_char(input logic [7:0] c, input logic l);
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= l;
        do @(posedge i_clk); while (!o_ready);
        chars_sent++;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Sends a whole string with the last-character flag on its final word.
    task automatic send_string(input t_chars s);
        foreach (s[i])
            send_char(s[i], i == s.size() - 1);
        strings_sent++;
    endtask

    // Holds the sender off until every predicted result word has arrived.
    // The pending count is sampled on the falling edge, after the checker
    // has finished its work for the preceding rising edge.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        t_chars s;
        int     n;
        int     pick;
        bit     paused_mid;
        paused_mid = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings. A full group of the highest sextet gives three
        // 0xff bytes; "AA=" with a non-alphabet fourth character gives one
        // byte and the fourth character is ignored; a pad in the fourth
        // place gives two bytes; a pad in the second place of the last group
        // is its own error.
        send_string(chars_of("////"));
        s = chars_of("AA=");
        s = {s, 8'hff};
        send_string(s);
        send_string(chars_of("Zz9="));
        send_string(chars_of("A==="));
        // A lone character with the last flag is a length error at once.
        s = {8'h00};
        send_string(s);
        // A bad character and a leading pad are each rejected immediately;
        // the rest of the string up to the last flag is dropped silently.
        s = {8'h00, 8'h51};
        send_string(s);
        send_string(chars_of("=x"));
        // A pad inside a group that does not end the string is caught when
        // that group's fourth character arrives.
        send_string(chars_of("AB=CD"));

        wait_drained();

        // Random strings. Most are well formed with random content, some are
        // broken versions of well-formed strings, and a few are pure noise.
        while (chars_sent < 100) begin
            if (chars_sent >= 80) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            if (!paused_mid && chars_sent >= 50) begin
                wait_drained();
                paused_mid = 1'b1;
            end

            s.delete();
            n = $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0)
                n = 5;
            repeat (n * 4) s = {s, b64_char(6'($urandom))};
            case ($urandom_range(0, 2))
                0: begin
                    repeat (4) s = {s, b64_char(6'($urandom))};
                end
                1: begin
                    // One-byte ending; the fourth character may be anything.
                    repeat (2) s = {s, b64_char(6'($urandom))};
                    s = {s, PAD_CHAR};
                    s = {s, $urandom_range(0, 1) ? PAD_CHAR : 8'($urandom)};
                end
                default: begin
                    repeat (3) s = {s, b64_char(6'($urandom))};
                    s = {s, PAD_CHAR};
                end
            endcase

            n = $urandom_range(0, 19);
            if (n < 12) begin
                clean_chars += s.size();
            end else if (n < 17) begin
                pick = $urandom_range(0, s.size() - 1);
                case ($urandom_range(0, 4))
                    0: s[pick] = 8'($urandom);
                    1: repeat ($urandom_range(1, 3)) if (s.size() > 1) void'(s.pop_back());
                    2: s[pick] = PAD_CHAR;
                    3: s[s.size() - 3] = PAD_CHAR;
                    default: repeat ($urandom_range(1, 3)) s = {s, b64_char(6'($urandom))};
                endcase
            end else begin
                s.delete();
                repeat ($urandom_range(1, 9)) begin
                    case ($urandom_range(0, 2))
                        0: s = {s, 8'($urandom)};
                        1: s = {s, b64_char(6'($urandom))};
                        default: s = {s, PAD_CHAR};
                    endcase
                end
            end
            send_string(s);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Sent %0d strings, %0d characters (%0d in well-formed random strings).",
                 strings_sent, chars_sent, clean_chars);
        $display("Checked %0d result words under random stalls on both channels.", checked);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/b64d_pkg.sv
rtl/core/b64d_decode.sv
rtl/core/b64d_out_fifo.sv
rtl/core/base64_stream_decoder.sv
tb/b64_decode_checker.sv
tb/tb_base64_stream_decoder.sv
